// ===== design/flpwm_pkg.sv =====
// flpwm_pkg: shared types and constants for the low-pass fir to pwm block
// holds the half coefficient table, gain and pwm limits, and the tap coefficient function
// no dependencies

package flpwm_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int GAIN_W     = 5;
	localparam int GAIN_CNT_W = $clog2(GAIN_W);
	localparam int MATCH_W    = 16;
	localparam int HALF_LEN   = 12;
	localparam int HALF_IDX_W = 4;
	localparam int COEF_MAX_W = 24;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(5);
	localparam logic [MATCH_W-1:0] PWM_MAX    = {MATCH_W{1'b1}};

	typedef logic signed [15:0] q15_t;
	typedef logic signed [COEF_MAX_W-1:0] coef_t;

	localparam q15_t HALF_COEF_Q15 [HALF_LEN] = '{
		-16'sd37, -16'sd137, -16'sd303, -16'sd488, -16'sd556, -16'sd336,
		16'sd338, 16'sd1501, 16'sd3011, 16'sd4540, 16'sd5688, 16'sd6112
	};

	// symmetric tap lookup, rescaled from q1.15 to coef_bits
	function automatic coef_t coef_for_tap(input int k, input int taps, input int coef_bits);
		int                      mirror;
		int                      idx;
		logic [HALF_IDX_W-1:0]   idx_s;
		q15_t                    c;
		logic                    neg;
		logic [COEF_MAX_W-1:0]   mag;
		mirror = taps - 1 - k;
		idx    = (k < mirror) ? k : mirror;
		if (idx >= HALF_LEN) begin
			idx = HALF_LEN - 1;
		end
		idx_s = HALF_IDX_W'(idx);
		c     = HALF_COEF_Q15[idx_s];
		neg   = c[15];
		mag   = neg ? COEF_MAX_W'(-c) : COEF_MAX_W'(c);
		if (coef_bits >= 16) begin
			mag = mag << (coef_bits - 16);
		end else begin
			mag = (mag + (COEF_MAX_W'(1) << (15 - coef_bits))) >> (16 - coef_bits);
		end
		return neg ? coef_t'(-mag) : coef_t'(mag);
	endfunction

endpackage

// ===== design/flpwm_scale.sv =====
// flpwm_scale: bit-serial gain multiply with saturation to the pwm range
// one gain bit per cycle, shift-and-add over the filter magnitude
// depends on flpwm_pkg

module flpwm_scale #(
	parameter int MAG_W = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [MAG_W-1:0]               mag,
	input  logic                           neg,
	input  logic [flpwm_pkg::GAIN_W-1:0]   gain,
	output logic                           done,
	output logic [flpwm_pkg::MATCH_W-1:0]  match,
	output logic                           clip
);
	import flpwm_pkg::*;

	localparam int PROD_W = MAG_W + GAIN_W;

	logic                  busy_q;
	logic                  done_q;
	logic [GAIN_CNT_W-1:0] cnt_q;
	logic [GAIN_W-1:0]     gain_sh_q;
	logic [PROD_W-1:0]     mag_sh_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == GAIN_CNT_W'(GAIN_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + GAIN_CNT_W'(1);
				if (cnt_q == GAIN_CNT_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_sh_q  <= PROD_W'(mag);
			gain_sh_q <= gain;
			prod_q    <= '0;
			neg_q     <= neg && (gain != '0);
		end else if (busy_q) begin
			if (gain_sh_q[0]) begin
				prod_q <= prod_q + mag_sh_q;
			end
			mag_sh_q  <= mag_sh_q << 1;
			gain_sh_q <= gain_sh_q >> 1;
		end
	end

	always_comb begin
		priority if (neg_q) begin
			match = '0;
			clip  = 1'b1;
		end else if (prod_q > PROD_W'(PWM_MAX)) begin
			match = PWM_MAX;
			clip  = 1'b1;
		end else begin
			match = prod_q[MATCH_W-1:0];
			clip  = 1'b0;
		end
	end

	assign done = done_q;

endmodule

// ===== design/fir_lowpass_to_pwm.sv =====
// fir_lowpass_to_pwm: symmetric low-pass fir on adc samples, scaled to a pwm match value
// single shared mac over a rotating delay line, then the bit-serial gain unit
// depends on flpwm_pkg and flpwm_scale
//
// usage:
//   input channel carries one 12-bit adc sample per item (in_valid / in_stall).
//   output channel carries duty_cmp and clipped per item (out_valid / out_stall).
//   cfg_we with cfg_wdata writes the 5-bit output gain; write it only while idle.
// timing:
//   after an item is taken the delay line rotates once per cycle through the
//   one multiply-accumulate, once for each tap, then the sum is truncated, the
//   bit-serial gain unit works one gain bit per cycle, and the result is handed
//   into the output register. a new item is taken only after the last one has
//   been handed into the output register.
//   in_stall is high while an item is being worked on.
// reset:
//   clears the delay line to zeros, sets the gain to 5, empties the output.
// receiver stall:
//   the output register holds its item; the next item may be taken and filtered
//   meanwhile and waits in the gain unit until the output register is free.

module fir_lowpass_to_pwm #(
	parameter int TAPS      = 23,
	parameter int COEF_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [flpwm_pkg::SAMPLE_W-1:0]   sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [flpwm_pkg::MATCH_W-1:0]    duty_cmp,
	output logic                             clipped,
	input  logic                             cfg_we,
	input  logic [flpwm_pkg::GAIN_W-1:0]     cfg_wdata
);
	import flpwm_pkg::*;

	localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int PROD_W = SAMPLE_W + COEF_BITS + 1;
	localparam int ACC_W  = SAMPLE_W + COEF_BITS + TAP_W + 1;
	localparam int MAG_W  = ACC_W - COEF_BITS + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	logic [1:0]                   state_q;
	logic [TAP_W-1:0]             tap_q;
	logic [SAMPLE_W-1:0]          dl_q [TAPS];
	logic signed [ACC_W-1:0]      acc_q;
	logic [GAIN_W-1:0]            gain_q;
	logic                         scale_wait_q;
	logic                         out_valid_q;
	logic [MATCH_W-1:0]           match_q;
	logic                         clip_q;

	coef_t                        coef_full;
	logic signed [COEF_BITS-1:0]  coef_cur;
	logic signed [PROD_W-1:0]     prod;
	logic [ACC_W-1:0]             acc_abs;
	logic [MAG_W-1:0]             mag;
	logic                         scale_start;
	logic                         scale_done;
	logic [MATCH_W-1:0]           scale_match;
	logic                         scale_clip;
	logic                         in_take;
	logic                         out_free;

	assign in_take  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		coef_full = coef_for_tap(int'(tap_q), TAPS, COEF_BITS);
		coef_cur  = coef_full[COEF_BITS-1:0];
		prod      = $signed({1'b0, dl_q[0]}) * coef_cur;
		acc_abs   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		mag       = acc_abs[ACC_W-1:COEF_BITS-1];
	end

	assign scale_start = (state_q == ST_TRUNC);

	flpwm_scale #(
		.MAG_W(MAG_W)
	) u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.mag    (mag),
		.neg    (acc_q[ACC_W-1] && (mag != '0)),
		.gain   (gain_q),
		.done   (scale_done),
		.match  (scale_match),
		.clip   (scale_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// delay line, newest at entry 0, rotated once per mac cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				dl_q[i] <= '0;
			end
		end else if (in_take) begin
			dl_q[0] <= sample;
			for (int i = 1; i < TAPS; i++) begin
				dl_q[i] <= dl_q[i-1];
			end
		end else if (state_q == ST_MAC) begin
			for (int i = 0; i < TAPS; i++) begin
				dl_q[i] <= dl_q[(i + 1) % TAPS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tap_q        <= '0;
			scale_wait_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_MAC;
						tap_q   <= '0;
					end
				end
				ST_MAC: begin
					tap_q <= tap_q + TAP_W'(1);
					if (tap_q == TAP_W'(TAPS - 1)) begin
						state_q <= ST_TRUNC;
					end
				end
				ST_TRUNC: begin
					state_q      <= ST_HOLD;
					scale_wait_q <= 1'b1;
				end
				ST_HOLD: begin
					if (scale_done) begin
						scale_wait_q <= 1'b0;
					end
					if (!scale_wait_q && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			acc_q <= '0;
		end else if (state_q == ST_MAC) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && !scale_wait_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && !scale_wait_q && out_free) begin
			match_q <= scale_match;
			clip_q  <= scale_clip;
		end
	end

	assign out_valid = out_valid_q;
	assign duty_cmp  = match_q;
	assign clipped   = clip_q;

endmodule

// ===== design/flpwm_check.sv =====
// flpwm_check: port-level checks for fir_lowpass_to_pwm
// bound to the top level at the end of this file
// depends on flpwm_pkg

module flpwm_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [flpwm_pkg::MATCH_W-1:0]    duty_cmp,
	input logic                             clipped
);
	import flpwm_pkg::*;

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty_cmp) && $stable(clipped))
		else $error("stalled output item changed");

	// a clipped result sits at one end of the range
	a_clip_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (duty_cmp == '0) || (duty_cmp == PWM_MAX))
		else $error("clipped result not at a range end");

	// the block is busy right after taking an item
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while not busy afterwards");

	// no result appears right after an item enters an idle block with an empty output
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind fir_lowpass_to_pwm flpwm_check u_flpwm_check (.*);

// ===== dv/tb_fir_lowpass_to_pwm.sv =====
`timescale 1ns / 100ps
// tb_fir_lowpass_to_pwm: self-checking bench for the 23-tap low-pass fir to pwm block
// predicts each pwm match from its own delay line and gain copy, random bursts and stalls
// depends on flpwm_pkg and the fir_lowpass_to_pwm rtl

module tb_fir_lowpass_to_pwm;
	import flpwm_pkg::*;

	localparam int     N_TAPS      = 23;
	localparam int     ACC_SHIFT   = 15;
	localparam int     PHASE_ITEMS = 215;
	localparam int     FILL_WAIT   = 40;
	localparam int     LONG_HOLD   = 400;
	localparam int     MAX_REPORTS = 10;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam int     ADC_MAX     = 4095;

	localparam int TAP_WEIGHT [12] = '{
		-37, -137, -303, -488, -556, -336, 338, 1501, 3011, 4540, 5688, 6112
	};

	typedef struct packed {
		logic [MATCH_W-1:0] match;
		logic               clip;
	} pwm_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] sample    = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [MATCH_W-1:0]  duty_cmp;
	logic                clipped;
	logic                cfg_we    = 1'b0;
	logic [GAIN_W-1:0]   cfg_wdata = '0;

	logic [SAMPLE_W-1:0] adc_pending [$];
	pwm_result_t         pwm_expected [$];
	logic [SAMPLE_W-1:0] hist [N_TAPS];
	int                  wr_pos;
	logic [GAIN_W-1:0]   gain_now;

	int     queued, items_in, results_seen, errors, neg_clips, high_clips;
	longint cycle_cnt;
	int     burst_left, gap_left, run_left, stall_left, hold_left;
	bit     hold_used, in_took;

	fir_lowpass_to_pwm uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.duty_cmp  (duty_cmp),
		.clipped   (clipped),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic pwm_result_t predict_pwm(input logic [SAMPLE_W-1:0] s);
		longint      acc;
		longint      filt;
		longint      prod;
		int          pos;
		int          idx;
		pwm_result_t r;
		acc = 0;
		hist[wr_pos] = s;
		pos = wr_pos;
		for (int k = 0; k < N_TAPS; k++) begin
			idx = (k < N_TAPS - 1 - k) ? k : N_TAPS - 1 - k;
			acc += longint'(TAP_WEIGHT[idx]) * longint'(hist[pos]);
			pos = (pos == 0) ? N_TAPS - 1 : pos - 1;
		end
		wr_pos = (wr_pos + 1) % N_TAPS;
		filt = (acc < 0) ? -((-acc) >>> ACC_SHIFT) : (acc >>> ACC_SHIFT);
		prod = filt * longint'(gain_now);
		if (prod < 0) begin
			r = '{match: '0, clip: 1'b1};
			neg_clips++;
		end else if (prod > longint'(PWM_MAX)) begin
			r = '{match: PWM_MAX, clip: 1'b1};
			high_clips++;
		end else begin
			r = '{match: MATCH_W'(prod), clip: 1'b0};
		end
		return r;
	endfunction

	function automatic void push_run(input int v, input int n);
		for (int i = 0; i < n; i++) begin
			adc_pending.push_back(SAMPLE_W'(v));
			queued++;
		end
	endfunction

	task automatic write_gain(input logic [GAIN_W-1:0] g);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(negedge clk);
		cfg_we    <= 1'b0;
		gain_now  = g;
	endtask

	task automatic drain_results();
		while (adc_pending.size() != 0 || in_valid || pwm_expected.size() != 0)
			@(negedge clk);
		repeat (FILL_WAIT) @(negedge clk);
	endtask

	task automatic queue_random(input int n);
		int target;
		int kind;
		int len;
		int hi;
		int lo;
		int h;
		int l;
		int v;
		int step;
		target = queued + n;
		while (queued < target) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: begin
					len = $urandom_range(1, 40);
					for (int i = 0; i < len; i++)
						push_run($urandom_range(0, ADC_MAX), 1);
				end
				3, 4: begin
					case ($urandom_range(0, 2))
						0: v = 0;
						1: v = ADC_MAX;
						default: v = $urandom_range(0, ADC_MAX);
					endcase
					push_run(v, $urandom_range(23, 50));
				end
				5, 6: begin
					hi  = $urandom_range(2048, ADC_MAX);
					lo  = $urandom_range(0, 1024);
					h   = $urandom_range(1, 12);
					l   = $urandom_range(1, 12);
					len = $urandom_range(2, 6);
					for (int i = 0; i < len; i++) begin
						push_run(hi, h);
						push_run(lo, l);
					end
				end
				7: begin
					// energy on the negative taps only
					hi = $urandom_range(3500, ADC_MAX);
					lo = $urandom_range(0, 200);
					push_run(hi, 6);
					push_run(lo, 11);
					push_run(hi, 6);
				end
				8: begin
					v    = $urandom_range(0, ADC_MAX);
					step = $urandom_range(1, 400);
					len  = $urandom_range(10, 40);
					for (int i = 0; i < len; i++) begin
						push_run(v, 1);
						v = (v + step) % (ADC_MAX + 1);
					end
				end
				default: begin
					len = $urandom_range(1, 5);
					for (int i = 0; i < len; i++)
						push_run($urandom_range(0, 1) ? ADC_MAX : 0, 1);
				end
			endcase
		end
	endtask

	// sender
	always @(negedge clk) begin
		logic                nv;
		logic [SAMPLE_W-1:0] ns;
		nv = in_valid;
		ns = sample;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!in_valid || in_took) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (adc_pending.size() > 0) begin
				nv = 1'b1;
				ns = adc_pending.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
			end
		end
		in_valid <= nv;
		sample   <= ns;
	end

	// receiver
	always @(negedge clk) begin
		logic st;
		if (hold_left > 0) begin
			st = 1'b1;
			hold_left--;
		end else if (!hold_used && results_seen >= 100 && adc_pending.size() > 30) begin
			hold_used = 1'b1;
			hold_left = LONG_HOLD;
			st        = 1'b1;
		end else if (run_left > 0) begin
			st = 1'b0;
			run_left--;
		end else if (stall_left > 0) begin
			st = 1'b1;
			stall_left--;
		end else begin
			st         = 1'b0;
			run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(0, 30);
			stall_left = $urandom_range(0, 12);
		end
		out_stall <= st;
	end

	// monitor and checker
	always @(posedge clk) begin
		pwm_result_t want;
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pwm_expected.push_back(predict_pwm(sample));
				items_in++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pwm_expected.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected item: duty_cmp %0d clipped %0d",
						         duty_cmp, clipped);
				end else begin
					want = pwm_expected.pop_front();
					if (want.match !== duty_cmp || want.clip !== clipped) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("item %0d mismatch: expected %0d/%0d, got %0d/%0d",
							         results_seen, want.match, want.clip, duty_cmp, clipped);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("fir_lowpass_to_pwm verification failed");
			$finish;
		end
	end

	initial begin
		logic [GAIN_W-1:0] phase_gain [8];
		phase_gain = '{5'd31, 5'd0, 5'd16, 5'd1, 5'd17, 5'd0, 5'd0, 5'd0};
		for (int i = 5; i < 8; i++)
			phase_gain[i] = GAIN_W'($urandom_range(0, 31));
		gain_now   = GAIN_RESET;
		wr_pos     = 0;
		burst_left = 1;
		foreach (hist[i])
			hist[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset gain, negative-tap pattern, then both sample extremes
		push_run(ADC_MAX, 6);
		push_run(0, 11);
		push_run(ADC_MAX, 6);
		push_run(ADC_MAX, 1);
		push_run(0, 1);
		drain_results();

		for (int p = 0; p < 8; p++) begin
			write_gain(phase_gain[p]);
			queue_random(PHASE_ITEMS);
			drain_results();
		end

		if (pwm_expected.size() != 0)
			errors++;
		$display("ran %0d samples through %0d gain settings, %0d results checked",
		         items_in, 9, results_seen);
		$display("saturated low %0d times and high %0d times, %0d mismatches",
		         neg_clips, high_clips, errors);
		if (errors == 0) begin
			$display("fir_lowpass_to_pwm verification clean");
		end else begin
			$display("fir_lowpass_to_pwm verification failed");
		end
		$finish;
	end

endmodule
